/* design/assert_macros.svh */
// assertion macros for the call-stack table design
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CDT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define CDT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define CDT_ASSERT(lbl, clk, rstn, prop, msg)
`define CDT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* design/cdt_pkg.sv */
// shared sizes, codes and types of the call-stack dedup table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cdt_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int MAX_FRAMES  = 32;
  localparam int NUM_SAMPLES = 8;

  // fixed field widths of the channels
  localparam int SAMPLE_W = 3;
  localparam int SEL_W    = 10;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 6;
  localparam int LIMIT_W  = 11;

  localparam int TABLE_LIMIT_RESET = 1024;

  // derived internal widths
  localparam int IDX_W      = $clog2(TABLE_DEPTH);
  localparam int FILL_W     = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int FRM_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int KEY_DEPTH  = TABLE_DEPTH * MAX_FRAMES;
  localparam int KEY_AW     = $clog2(KEY_DEPTH);
  localparam int SAMP_DEPTH = TABLE_DEPTH * NUM_SAMPLES;
  localparam int SAMP_AW    = (SAMP_DEPTH > 1) ? $clog2(SAMP_DEPTH) : 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_END   = 2'd1,
    OP_OVF   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    op_e                 op;
    logic [SAMPLE_W-1:0] sample;
    logic [WORD_W-1:0]   size;
    logic [WORD_W-1:0]   addr;
    logic [CNT_W-1:0]    cnt;
    logic [SEL_W-1:0]    sel;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [SEL_W-1:0]   index;
    logic               fresh;
    logic [WORD_W-1:0]  size;
    logic [COUNT_W-1:0] count;
    logic [WORD_W-1:0]  first;
  } res_t;

  typedef struct packed {
    logic clearing;
  } back_sts_t;

endpackage
`default_nettype wire

/* design/cdt_in_if.sv */
// request channel into the call-stack table
// depends on cdt_pkg
`timescale 1ns / 1ps
`default_nettype none
interface cdt_in_if import cdt_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [SAMPLE_W-1:0]        sample_index;
  logic signed [WORD_W-1:0]   alloc_size;
  logic [WORD_W-1:0]          frame_address;
  logic                       frame_last;
  logic [SEL_W-1:0]           entry_select;

  modport source (output valid, mode, sample_index, alloc_size, frame_address,
                  frame_last, entry_select, input ready);
  modport sink (input valid, mode, sample_index, alloc_size, frame_address,
                frame_last, entry_select, output ready);
endinterface
`default_nettype wire

/* design/cdt_out_if.sv */
// result channel out of the call-stack table
// depends on cdt_pkg
`timescale 1ns / 1ps
`default_nettype none
interface cdt_out_if import cdt_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [SEL_W-1:0]         entry_index;
  logic                     is_new;
  logic signed [WORD_W-1:0] size_value;
  logic [COUNT_W-1:0]       frame_count;
  logic [WORD_W-1:0]        first_address;

  modport source (output valid, status, entry_index, is_new, size_value, frame_count,
                  first_address, input ready);
  modport sink (input valid, status, entry_index, is_new, size_value, frame_count,
                first_address, output ready);
endinterface
`default_nettype wire

/* design/cdt_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module cdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* design/cdt_fifo.sv */
// short command queue between the front and the back of the table
// depends on cdt_pkg
`timescale 1ns / 1ps
`default_nettype none
module cdt_fifo import cdt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output logic      empty_o,
  output logic      full_o
);

  cmd_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

/* design/cdt_front.sv */
// front end: accepts requests, counts frames of the open record, classifies
// depends on cdt_pkg and cdt_in_if
`timescale 1ns / 1ps
`default_nettype none
module cdt_front import cdt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  cdt_in_if.sink         in_i,
  input  wire back_sts_t sts_i,
  input  wire logic      full_i,
  output logic           push_o,
  output cmd_t           cmd_o
);

  logic [CNT_W-1:0] pcnt_q, pcnt_d;
  logic             acc;

  assign in_i.ready = !full_i && !sts_i.clearing;
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    cmd_o.op     = OP_FRAME;
    cmd_o.sample = in_i.sample_index;
    cmd_o.size   = in_i.alloc_size;
    cmd_o.addr   = in_i.frame_address;
    cmd_o.cnt    = pcnt_q;
    cmd_o.sel    = in_i.entry_select;
    push_o       = 1'b0;
    pcnt_d       = pcnt_q;
    if (acc) begin
      if (in_i.mode) begin
        push_o   = 1'b1;
        cmd_o.op = OP_READ;
      end else if (pcnt_q < CNT_W'(MAX_FRAMES)) begin
        push_o   = 1'b1;
        cmd_o.op = in_i.frame_last ? OP_END : OP_FRAME;
        pcnt_d   = in_i.frame_last ? '0 : pcnt_q + 1'b1;
      end else begin
        // frame dropped, record is flagged once it ends
        push_o   = in_i.frame_last;
        cmd_o.op = OP_OVF;
        pcnt_d   = in_i.frame_last ? '0 : pcnt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= '0;
    end else begin
      pcnt_q <= pcnt_d;
    end
  end

endmodule
`default_nettype wire

/* design/cdt_back.sv */
// back end: collects frames, searches and fills the table, answers reads
// depends on cdt_pkg, cdt_out_if, cdt_ram and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cdt_back import cdt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               head_i,
  input  wire logic               empty_i,
  output logic                    pop_o,
  input  wire logic [LIMIT_W-1:0] table_limit_i,
  output back_sts_t               sts_o,
  cdt_out_if.source               out_o
);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_RD_WAIT = 10'b0000000100,
    S_LEN_RD  = 10'b0000001000,
    S_LEN_CHK = 10'b0000010000,
    S_FRM_RD  = 10'b0000100000,
    S_FRM_CHK = 10'b0001000000,
    S_CP_RD   = 10'b0010000000,
    S_CP_WR   = 10'b0100000000,
    S_EMIT    = 10'b1000000000
  } state_e;

  function automatic logic [KEY_AW-1:0] key_addr(input logic [IDX_W-1:0] s,
                                                 input logic [CNT_W-1:0] f);
    key_addr = KEY_AW'(s) * KEY_AW'(MAX_FRAMES) + KEY_AW'(f);
  endfunction

  function automatic logic [SAMP_AW-1:0] samp_addr(input logic [IDX_W-1:0] s,
                                                   input logic [SAMPLE_W-1:0] k);
    samp_addr = SAMP_AW'(s) * SAMP_AW'(NUM_SAMPLES) + SAMP_AW'(k);
  endfunction

  state_e              state_q, state_d;
  logic [FILL_W-1:0]   slot_q, slot_d, fill_q, fill_d, limit;
  logic [CNT_W-1:0]    i_q, i_d, tot_q, tot_d;
  logic [WORD_W-1:0]   first_q, first_d;
  logic [SAMP_AW-1:0]  clr_q, clr_d;
  cmd_t                cmd_q, cmd_d;
  res_t                res_q, res_d, out_q, out_d;
  logic                ov_q, ov_d;
  logic                out_free, smp_ok;

  logic                key_we, pend_we, len_we, samp_we;
  logic [KEY_AW-1:0]   key_waddr, key_raddr;
  logic [FRM_W-1:0]    pend_waddr, pend_raddr;
  logic [IDX_W-1:0]    len_waddr, len_raddr;
  logic [SAMP_AW-1:0]  samp_waddr, samp_raddr;
  logic [WORD_W-1:0]   samp_wdata;
  logic [WORD_W-1:0]   key_rd, pend_rd, samp_rd;
  logic [CNT_W-1:0]    len_rd;

  cdt_ram #(.WIDTH(WORD_W), .DEPTH(KEY_DEPTH)) u_key (
    .clk_i, .we_i(key_we), .waddr_i(key_waddr), .wdata_i(pend_rd),
    .raddr_i(key_raddr), .rdata_o(key_rd)
  );

  cdt_ram #(.WIDTH(WORD_W), .DEPTH(MAX_FRAMES)) u_pend (
    .clk_i, .we_i(pend_we), .waddr_i(pend_waddr), .wdata_i(head_i.addr),
    .raddr_i(pend_raddr), .rdata_o(pend_rd)
  );

  cdt_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_DEPTH)) u_len (
    .clk_i, .we_i(len_we), .waddr_i(len_waddr), .wdata_i(tot_q),
    .raddr_i(len_raddr), .rdata_o(len_rd)
  );

  cdt_ram #(.WIDTH(WORD_W), .DEPTH(SAMP_DEPTH)) u_samp (
    .clk_i, .we_i(samp_we), .waddr_i(samp_waddr), .wdata_i(samp_wdata),
    .raddr_i(samp_raddr), .rdata_o(samp_rd)
  );

  assign limit = (32'(table_limit_i) < TABLE_DEPTH) ? FILL_W'(table_limit_i)
                                                     : FILL_W'(TABLE_DEPTH);
  assign smp_ok         = (32'(cmd_q.sample) < NUM_SAMPLES);
  assign out_free       = !ov_q || out_o.ready;
  assign sts_o.clearing = (state_q == S_CLEAR);

  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    fill_d     = fill_q;
    i_d        = i_q;
    tot_d      = tot_q;
    first_d    = first_q;
    clr_d      = clr_q;
    cmd_d      = cmd_q;
    res_d      = res_q;
    out_d      = out_q;
    ov_d       = ov_q && !out_o.ready;
    pop_o      = 1'b0;
    key_we     = 1'b0;
    pend_we    = 1'b0;
    len_we     = 1'b0;
    samp_we    = 1'b0;
    key_waddr  = key_addr(slot_q[IDX_W-1:0], i_q);
    key_raddr  = key_addr(slot_q[IDX_W-1:0], i_q);
    pend_waddr = head_i.cnt[FRM_W-1:0];
    pend_raddr = i_q[FRM_W-1:0];
    len_waddr  = fill_q[IDX_W-1:0];
    len_raddr  = slot_q[IDX_W-1:0];
    samp_waddr = samp_addr(slot_q[IDX_W-1:0], cmd_q.sample);
    samp_raddr = samp_addr(IDX_W'(head_i.sel), head_i.sample);
    samp_wdata = cmd_q.size;
    case (state_q)
      S_CLEAR: begin
        samp_we    = 1'b1;
        samp_waddr = clr_q;
        samp_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == SAMP_AW'(SAMP_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          res_d = '0;
          case (head_i.op)
            OP_FRAME, OP_END: begin
              pend_we = 1'b1;
              if (head_i.cnt == '0) begin
                first_d = head_i.addr;
              end
              if (head_i.op == OP_END) begin
                tot_d   = head_i.cnt + 1'b1;
                slot_d  = '0;
                state_d = S_LEN_RD;
              end
            end
            OP_OVF: begin
              res_d.status = ST_OVF;
              state_d      = S_EMIT;
            end
            OP_READ: begin
              if (FILL_W'(head_i.sel) >= fill_q) begin
                res_d.status = ST_EMPTY;
                res_d.index  = head_i.sel;
                state_d      = S_EMIT;
              end else begin
                len_raddr = IDX_W'(head_i.sel);
                key_raddr = key_addr(IDX_W'(head_i.sel), '0);
                state_d   = S_RD_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_WAIT: begin
        res_d.status = ST_OK;
        res_d.index  = cmd_q.sel;
        res_d.size   = smp_ok ? samp_rd : '0;
        res_d.count  = COUNT_W'(len_rd);
        res_d.first  = key_rd;
        state_d      = S_EMIT;
      end
      S_LEN_RD: begin
        if (slot_q == fill_q) begin
          if (fill_q >= limit) begin
            res_d.status = ST_FULL;
            state_d      = S_EMIT;
          end else begin
            len_we  = 1'b1;
            i_d     = '0;
            state_d = S_CP_RD;
          end
        end else begin
          state_d = S_LEN_CHK;
        end
      end
      S_LEN_CHK: begin
        if (len_rd == tot_q) begin
          i_d     = '0;
          state_d = S_FRM_RD;
        end else begin
          slot_d  = slot_q + 1'b1;
          state_d = S_LEN_RD;
        end
      end
      S_FRM_RD: begin
        if (i_q == tot_q) begin
          // matched an existing stack
          samp_we      = smp_ok;
          res_d.status = ST_OK;
          res_d.index  = SEL_W'(slot_q);
          res_d.fresh  = 1'b0;
          res_d.count  = COUNT_W'(tot_q);
          res_d.first  = first_q;
          state_d      = S_EMIT;
        end else begin
          state_d = S_FRM_CHK;
        end
      end
      S_FRM_CHK: begin
        if (key_rd == pend_rd) begin
          i_d     = i_q + 1'b1;
          state_d = S_FRM_RD;
        end else begin
          slot_d  = slot_q + 1'b1;
          state_d = S_LEN_RD;
        end
      end
      S_CP_RD: begin
        if (i_q == tot_q) begin
          fill_d       = fill_q + 1'b1;
          samp_we      = smp_ok;
          res_d.status = ST_OK;
          res_d.index  = SEL_W'(slot_q);
          res_d.fresh  = 1'b1;
          res_d.count  = COUNT_W'(tot_q);
          res_d.first  = first_q;
          state_d      = S_EMIT;
        end else begin
          state_d = S_CP_WR;
        end
      end
      S_CP_WR: begin
        key_we  = 1'b1;
        i_d     = i_q + 1'b1;
        state_d = S_CP_RD;
      end
      S_EMIT: begin
        if (out_free) begin
          out_d   = res_q;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      fill_q  <= '0;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    i_q     <= i_d;
    tot_q   <= tot_d;
    first_q <= first_d;
    cmd_q   <= cmd_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_o.valid         = ov_q;
  assign out_o.status        = out_q.status;
  assign out_o.entry_index   = out_q.index;
  assign out_o.is_new        = out_q.fresh;
  assign out_o.size_value    = $signed(out_q.size);
  assign out_o.frame_count   = out_q.count;
  assign out_o.first_address = out_q.first;

  `CDT_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= FILL_W'(TABLE_DEPTH), "fill beyond depth")
  `CDT_ASSERT_IMP(a_clear_quiet, clk_i, rst_ni, state_q == S_CLEAR, !ov_q, "result in clear")
  `CDT_ASSERT_IMP(a_slot_filled, clk_i, rst_ni, state_q == S_LEN_CHK, slot_q < fill_q,
                  "search past fill")
  `CDT_ASSERT_IMP(a_frame_range, clk_i, rst_ni, state_q == S_FRM_CHK, i_q < tot_q,
                  "compare past record")

endmodule
`default_nettype wire

/* design/callstack_dedup_table.sv */
// Call-stack dedup table. Ingest requests (mode 0) carry one frame each and are
// taken one per cycle while the command queue has room and no clear runs; the
// frame that carries frame_last closes the record and starts a linear search over
// the filled slots: each slot's length is read and checked, the frames of a slot
// of the same length are read and compared in turn, and if none matches the new
// stack is copied in. A four-deep command queue sits between the front and the
// search engine, so frames of the next record are taken while a search runs,
// until the queue fills. After reset the size store is swept to zero, one word a
// cycle, over all TABLE_DEPTH*NUM_SAMPLES (8192) words, during which no request is
// taken; table_limit can be written over the APB port at any time it is idle.
// top level; depends on cdt_pkg, cdt_in_if, cdt_out_if, cdt_front, cdt_fifo, cdt_back
`timescale 1ns / 1ps
`default_nettype none
module callstack_dedup_table import cdt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  cdt_in_if.sink           in_i,
  cdt_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [LIMIT_W-1:0] limit_q, limit_d;
  back_sts_t          sts;
  cmd_t               cmd, head;
  logic               push, pop, empty, full;

  // single register, any address in the window selects it
  assign pready = 1'b1;
  assign prdata = 32'(limit_q) | (32'(paddr) & 32'h0);
  assign limit_d = (psel && penable && pwrite) ? pwdata[LIMIT_W-1:0] : limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_W'(TABLE_LIMIT_RESET);
    end else begin
      limit_q <= limit_d;
    end
  end

  cdt_front u_front (
    .clk_i, .rst_ni, .in_i, .sts_i(sts), .full_i(full), .push_o(push), .cmd_o(cmd)
  );

  cdt_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(cmd), .pop_i(pop), .head_o(head),
    .empty_o(empty), .full_o(full)
  );

  cdt_back u_back (
    .clk_i, .rst_ni, .head_i(head), .empty_i(empty), .pop_o(pop),
    .table_limit_i(limit_q), .sts_o(sts), .out_o
  );

endmodule
`default_nettype wire

/* tb/tb.sv */
// testbench for callstack_dedup_table: drives stack records and reads, predicts
// every result in a scoreboard class and compares them field by field
// depends on cdt_pkg, cdt_in_if, cdt_out_if and the callstack_dedup_table rtl
`timescale 1ns / 1ps

import cdt_pkg::*;

class dedup_scoreboard;
  bit [WORD_W-1:0]  stack_frames [TABLE_DEPTH][MAX_FRAMES];
  bit [COUNT_W-1:0] stack_len [TABLE_DEPTH];
  bit [WORD_W-1:0]  slot_size [TABLE_DEPTH][NUM_SAMPLES];
  int unsigned      filled;
  int unsigned      slot_limit;
  bit [WORD_W-1:0]  open_frames [MAX_FRAMES];
  int unsigned      open_count;
  bit               open_overflow;
  res_t             expected_results [$];
  int               errors, results, inserts, hits, overflows, fulls, empties;

  function new();
    filled = 0;
    slot_limit = TABLE_LIMIT_RESET;
    open_count = 0;
    open_overflow = 0;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  task report(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    $display("%0t mismatch on %s: expected %h, got %h", $realtime, field, want, got);
    errors++;
  endtask

  // predict the answer (if any) to one accepted request
  function void note_request(bit mode, bit [SAMPLE_W-1:0] sample, bit [WORD_W-1:0] size,
                             bit [WORD_W-1:0] addr, bit last, bit [SEL_W-1:0] sel);
    res_t r;
    int unsigned slot, lim, i;
    bit found, same;
    r = '0;
    if (mode) begin
      r.index = sel;
      if (sel >= filled) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_OK;
        r.size = slot_size[sel][sample];
        r.count = stack_len[sel];
        r.first = stack_frames[sel][0];
      end
      expected_results.push_back(r);
      return;
    end
    if (open_count < MAX_FRAMES) begin
      open_frames[open_count] = addr;
      open_count++;
    end else begin
      open_overflow = 1;
    end
    if (!last) return;
    if (open_overflow) begin
      r.status = ST_OVF;
    end else begin
      found = 0;
      slot = 0;
      while (slot < filled && !found) begin
        same = (stack_len[slot] == open_count);
        for (i = 0; same && i < open_count; i++)
          if (stack_frames[slot][i] != open_frames[i]) same = 0;
        if (same) found = 1;
        else slot++;
      end
      lim = (slot_limit < TABLE_DEPTH) ? slot_limit : TABLE_DEPTH;
      if (!found && filled >= lim) begin
        r.status = ST_FULL;
      end else begin
        if (!found) begin
          slot = filled;
          stack_len[slot] = COUNT_W'(open_count);
          for (i = 0; i < open_count; i++) stack_frames[slot][i] = open_frames[i];
          filled++;
          r.fresh = 1;
        end
        slot_size[slot][sample] = size;
        r.status = ST_OK;
        r.index = SEL_W'(slot);
        r.count = stack_len[slot];
        r.first = stack_frames[slot][0];
      end
    end
    open_count = 0;
    open_overflow = 0;
    expected_results.push_back(r);
  endfunction

  task check_result(res_t got);
    res_t want;
    results++;
    if (expected_results.size() == 0) begin
      report("unexpected result status", '0, got.status);
      return;
    end
    want = expected_results.pop_front();
    if (want.status != got.status) report("status", want.status, got.status);
    if (want.index != got.index) report("entry_index", want.index, got.index);
    if (want.fresh != got.fresh) report("is_new", want.fresh, got.fresh);
    if (want.size != got.size) report("size_value", want.size, got.size);
    if (want.count != got.count) report("frame_count", want.count, got.count);
    if (want.first != got.first) report("first_address", want.first, got.first);
    case (want.status)
      ST_OK: begin
        if (want.fresh) inserts++;
        else hits++;
      end
      ST_OVF: overflows++;
      ST_FULL: fulls++;
      default: empties++;
    endcase
  endtask
endclass

module tb;
  localparam logic [1:0] REG_TABLE_LIMIT = 2'd0;
  localparam int POOL_SIZE = 24;
  localparam int SETTLE_CYCLES = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;

  cdt_in_if  in_if ();
  cdt_out_if out_if ();

  callstack_dedup_table DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dedup_scoreboard sb = new();
  bit send_idle = 1;
  bit recv_stall = 1;
  int records_sent, reads_sent;
  bit [WORD_W-1:0] stack_pool [POOL_SIZE][$];

  // low first, so the first rising edge comes after time zero
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task send_item(bit mode, bit [SAMPLE_W-1:0] sample, bit [WORD_W-1:0] size,
                 bit [WORD_W-1:0] addr, bit last, bit [SEL_W-1:0] sel);
    int n;
    in_if.valid <= 1'b1;
    in_if.mode <= mode;
    in_if.sample_index <= sample;
    in_if.alloc_size <= size;
    in_if.frame_address <= addr;
    in_if.frame_last <= last;
    in_if.entry_select <= sel;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_request(mode, sample, size, addr, last, sel);
    n = send_idle ? gap_len() : 0;
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task read_entry(bit [SEL_W-1:0] sel, bit [SAMPLE_W-1:0] sample);
    send_item(1'b1, sample, $urandom, $urandom, 1'($urandom_range(0, 1)), sel);
    reads_sent++;
  endtask

  // one stack record, with an occasional read slipped in between frames
  task send_record(bit [WORD_W-1:0] frames [$], bit [SAMPLE_W-1:0] sample,
                   bit [WORD_W-1:0] size, int read_pct);
    int i;
    for (i = 0; i < frames.size(); i++) begin
      if (i > 0 && $urandom_range(0, 99) < read_pct)
        read_entry(SEL_W'($urandom_range(0, sb.filled + 2)), SAMPLE_W'($urandom));
      if (i == frames.size() - 1)
        send_item(1'b0, sample, size, frames[i], 1'b1, SEL_W'($urandom));
      else
        send_item(1'b0, SAMPLE_W'($urandom), $urandom, frames[i], 1'b0, SEL_W'($urandom));
    end
    records_sent++;
  endtask

  task wait_drained();
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  task write_limit(bit [LIMIT_W-1:0] value);
    in_if.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_TABLE_LIMIT;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.slot_limit = value;
  endtask

  function automatic void random_stack(ref bit [WORD_W-1:0] q [$], input int len);
    q.delete();
    repeat (len) q.push_back($urandom);
  endfunction

  task random_phase(int items);
    bit [WORD_W-1:0] q [$];
    int k, sent, r, len;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        if ($urandom_range(0, 1))
          read_entry(SEL_W'($urandom_range(0, sb.filled + 2)), SAMPLE_W'($urandom));
        else read_entry(SEL_W'($urandom), SAMPLE_W'($urandom));
        sent++;
      end else begin
        if (r < 75) begin
          q = stack_pool[$urandom_range(0, POOL_SIZE - 1)];
          if ($urandom_range(0, 9) == 0) q[$urandom_range(0, q.size() - 1)] = $urandom;
        end else begin
          k = $urandom_range(0, 99);
          len = (k < 80) ? $urandom_range(1, 6) : (k < 93) ? $urandom_range(7, MAX_FRAMES)
                : $urandom_range(MAX_FRAMES + 1, MAX_FRAMES + 6);
          random_stack(q, len);
        end
        send_record(q, SAMPLE_W'($urandom), $urandom, 5);
        sent += q.size();
      end
    end
  endtask

  initial begin
    bit [WORD_W-1:0] q [$];
    int i, k;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.mode = 1'b0;
    in_if.sample_index = '0;
    in_if.alloc_size = '0;
    in_if.frame_address = '0;
    in_if.frame_last = 1'b0;
    in_if.entry_select = '0;
    for (i = 0; i < POOL_SIZE; i++) begin
      k = $urandom_range(0, 9);
      random_stack(stack_pool[i], (k < 8) ? $urandom_range(1, 5) : $urandom_range(6, MAX_FRAMES));
    end
    // two pool stacks share a prefix, so length alone tells them apart
    stack_pool[1] = stack_pool[0];
    stack_pool[1].push_back($urandom);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    read_entry(0, 0);
    read_entry(SEL_W'(TABLE_DEPTH - 1), 7);
    q = {32'h0000_0000};
    send_record(q, 0, 32'h8000_0000, 0);
    send_record(q, 7, 32'h7fff_ffff, 0);
    q = {32'hffff_ffff};
    send_record(q, 7, 32'hffff_ffff, 0);
    read_entry(0, 0);
    read_entry(0, 7);
    read_entry(1, 7);
    read_entry(2, 3);
    random_stack(q, MAX_FRAMES);
    send_record(q, 3, 32'h1234_5678, 0);
    random_stack(q, MAX_FRAMES + 1);
    send_record(q, 4, $urandom, 0);
    // a read in the middle of a record
    q = {32'hdead_beef, 32'h0bad_f00d, 32'h1111_2222};
    send_record(q, 5, 32'h0000_0001, 100);
    q = {32'hdead_beef, 32'h0bad_f00d};
    send_record(q, 6, 32'h0000_0002, 0);
    read_entry(4, 5);

    write_limit(LIMIT_W'(1));
    q = {32'h5555_aaaa};
    send_record(q, 1, $urandom, 0);
    q = {32'h0000_0000};
    send_record(q, 2, 32'h0000_00ff, 0);
    read_entry(0, 2);

    write_limit(LIMIT_W'(TABLE_LIMIT_RESET));
    random_phase(150);

    // no idling for a while
    send_idle = 0;
    recv_stall = 0;
    random_phase(60);
    send_idle = 1;
    recv_stall = 1;

    // hold off until the table has answered everything
    in_if.valid <= 1'b0;
    wait_drained();
    random_phase(60);

    write_limit(LIMIT_W'(sb.filled + 3));
    random_phase(80);
    write_limit(LIMIT_W'(1));
    random_phase(50);
    write_limit(LIMIT_W'(TABLE_LIMIT_RESET));
    random_phase(100);

    in_if.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("ran %0d records and %0d reads: %0d inserts, %0d hits, %0d too long,",
             records_sent, reads_sent, sb.inserts, sb.hits, sb.overflows);
    $display("%0d table full, %0d empty-slot reads, %0d slots filled, %0d results",
             sb.fulls, sb.empties, sb.filled, sb.results);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side with random backpressure
  initial begin
    int hold;
    res_t got;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.status = status_e'(out_if.status);
        got.index = out_if.entry_index;
        got.fresh = out_if.is_new;
        got.size = out_if.size_value;
        got.count = out_if.frame_count;
        got.first = out_if.first_address;
        sb.check_result(got);
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        hold = recv_stall ? gap_len() : 0;
        out_if.ready <= (hold == 0);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
